[hw/rtl/mic_e_position_decoder_core_assert.svh]
// ----------------------------------------------------------------------------
// mic_e_position_decoder_core_assert.svh
// Assertion macros used by the Mic-E decoder checker.
// ----------------------------------------------------------------------------
`ifndef MIC_E_POSITION_DECODER_CORE_ASSERT_SVH
`define MIC_E_POSITION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MEPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MEPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mepd_pkg.sv]
// ----------------------------------------------------------------------------
// mepd_pkg
// Types, character codes and helpers for the Mic-E position decoder.
// ----------------------------------------------------------------------------
package mepd_pkg;

	localparam int LAT_LANES = 6;
	localparam int LON_LANES = 3;

	// lane roles
	localparam int LANE_MIN_UNITS  = 3;
	localparam int LANE_HUND_TENS  = 4;
	localparam int LANE_HUND_UNITS = 5;
	localparam int LANE_DEG        = 0;
	localparam int LANE_MIN        = 1;
	localparam int LANE_HUND       = 2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_J     = 8'h4A;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [7:0] BYTE_OFFSET = 8'd28;
	localparam logic [7:0] BYTE_MAX    = 8'd127;

	localparam logic [7:0] DEG_HUNDRED  = 8'd100;
	localparam logic [7:0] FOLD_LO      = 8'd180;
	localparam logic [7:0] FOLD_HI      = 8'd189;
	localparam logic [7:0] FOLD_SUB     = 8'd80;
	localparam logic [7:0] WRAP_LO      = 8'd190;
	localparam logic [7:0] WRAP_HI      = 8'd199;
	localparam logic [6:0] MIN_WRAP     = 7'd60;
	localparam logic [14:0] DIV10_MUL   = 15'd205;

	typedef struct packed {
		logic [7:0] ch;        // ASCII digit or space
		logic       is_digit;  // raw byte was '0'..'9'
		logic       at_p;      // raw byte >= 'P'
	} lat_lane_t;

	typedef struct packed {
		logic [6:0] val;       // byte minus offset, meaningful when !bad
		logic       bad;
	} lon_lane_t;

	// x / 10 for x < 128 by reciprocal multiply
	function automatic logic [3:0] div10(input logic [6:0] x);
		logic [14:0] p;
		p = 15'(x) * DIV10_MUL;
		return p[14:11];
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return CH_ZERO + {4'b0000, d};
	endfunction

	// two ASCII digits of a value 0..99
	function automatic logic [15:0] two_digits(input logic [6:0] x);
		logic [3:0] t;
		logic [6:0] u;
		t = div10(x);
		u = x - 7'(t) * 7'd10;
		return {digit_char(t), digit_char(u[3:0])};
	endfunction

endpackage

[hw/rtl/mic_e_position_decoder_core.sv]
// Mic-E position decoder. Takes one report word per cycle and gives one
// result word per cycle while out_ready is high; each word passes through the lane
// register, then the output register. Six latitude lanes and three longitude
// lanes decode in parallel and a merge stage builds the text words.
// in_ready follows out_ready combinationally through the two-stage enable
// chain. There is no state machine and no configuration.
// ----------------------------------------------------------------------------
// mic_e_position_decoder_core
// Top level: lanes, pipeline registers and valid/ready control.
// ----------------------------------------------------------------------------
module mic_e_position_decoder_core
	import mepd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  dest_char_0,
	input  logic [7:0]  dest_char_1,
	input  logic [7:0]  dest_char_2,
	input  logic [7:0]  dest_char_3,
	input  logic [7:0]  dest_char_4,
	input  logic [7:0]  dest_char_5,
	input  logic [7:0]  degree_byte,
	input  logic [7:0]  minute_byte,
	input  logic [7:0]  hundredth_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] latitude_text,
	output logic [63:0] longitude_text,
	output logic        west,
	output logic        field_error
);

	logic [LAT_LANES-1:0][7:0] dest_chars;
	logic [LON_LANES-1:0][7:0] info_bytes;
	lat_lane_t [LAT_LANES-1:0] lat_lane;
	lon_lane_t [LON_LANES-1:0] lon_lane;
	lat_lane_t [LAT_LANES-1:0] lat_s1;
	lon_lane_t [LON_LANES-1:0] lon_s1;
	logic                      valid_s1;
	logic                      out_valid_q;
	logic [63:0]               lat_text_q;
	logic [63:0]               lon_text_q;
	logic                      west_q;
	logic                      err_q;
	logic [63:0]               lat_text_m;
	logic [63:0]               lon_text_m;
	logic                      west_m;
	logic                      err_m;
	logic                      out_adv;

	assign dest_chars = {dest_char_5, dest_char_4, dest_char_3,
		dest_char_2, dest_char_1, dest_char_0};
	assign info_bytes = {hundredth_byte, minute_byte, degree_byte};

	for (genvar i = 0; i < LAT_LANES; i++) begin : g_lat
		mepd_lat_lane u_lane (.dest_char(dest_chars[i]), .lane(lat_lane[i]));
	end

	for (genvar i = 0; i < LON_LANES; i++) begin : g_lon
		mepd_lon_lane u_lane (.info_byte(info_bytes[i]), .lane(lon_lane[i]));
	end

	mepd_merge u_merge (
		.lat         (lat_s1),
		.lon         (lon_s1),
		.lat_text    (lat_text_m),
		.lon_text    (lon_text_m),
		.west        (west_m),
		.field_error (err_m)
	);

	assign out_adv  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (out_adv) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lat_s1 <= lat_lane;
			lon_s1 <= lon_lane;
		end
		if (valid_s1 && out_adv) begin
			lat_text_q <= lat_text_m;
			lon_text_q <= lon_text_m;
			west_q     <= west_m;
			err_q      <= err_m;
		end
	end

	assign out_valid      = out_valid_q;
	assign latitude_text  = lat_text_q;
	assign longitude_text = lon_text_q;
	assign west           = west_q;
	assign field_error    = err_q;

endmodule

[hw/rtl/mepd_lat_lane.sv]
// ----------------------------------------------------------------------------
// mepd_lat_lane
// Maps one destination character to its latitude digit and flags.
// ----------------------------------------------------------------------------
module mepd_lat_lane
	import mepd_pkg::*;
(
	input  logic [7:0] dest_char,
	output lat_lane_t  lane
);

	always_comb begin
		lane.is_digit = (dest_char inside {[CH_ZERO:CH_NINE]});
		lane.at_p     = (dest_char >= CH_P);
		if (dest_char inside {[CH_ZERO:CH_NINE]}) begin
			lane.ch = dest_char;
		end else if (dest_char inside {[CH_A:CH_J]}) begin
			lane.ch = dest_char - (CH_A - CH_ZERO);
		end else if (dest_char inside {[CH_P:CH_Y]}) begin
			lane.ch = dest_char - (CH_P - CH_ZERO);
		end else begin
			lane.ch = CH_SPACE;
		end
	end

endmodule

[hw/rtl/mepd_lon_lane.sv]
// ----------------------------------------------------------------------------
// mepd_lon_lane
// Removes the offset from one longitude info byte and range-checks it.
// ----------------------------------------------------------------------------
module mepd_lon_lane
	import mepd_pkg::*;
(
	input  logic [7:0] info_byte,
	output lon_lane_t  lane
);

	logic [7:0] diff;

	assign diff     = info_byte - BYTE_OFFSET;
	assign lane.val = diff[6:0];
	assign lane.bad = (info_byte < BYTE_OFFSET) || (info_byte > BYTE_MAX);

endmodule

[hw/rtl/mepd_merge.sv]
// ----------------------------------------------------------------------------
// mepd_merge
// Combines lane results into the latitude and longitude text words.
// ----------------------------------------------------------------------------
module mepd_merge
	import mepd_pkg::*;
(
	input  lat_lane_t [LAT_LANES-1:0] lat,
	input  lon_lane_t [LON_LANES-1:0] lon,
	output logic [63:0]               lat_text,
	output logic [63:0]               lon_text,
	output logic                      west,
	output logic                      field_error
);

	logic [7:0]  deg_raw;
	logic [7:0]  deg_fold;
	logic        deg_hund;
	logic [7:0]  deg_rem;
	logic [6:0]  min_val;

	assign field_error = lon[LANE_DEG].bad | lon[LANE_MIN].bad | lon[LANE_HUND].bad;
	assign west        = lat[LANE_HUND_UNITS].at_p;

	assign lat_text = {lat[0].ch, lat[1].ch, lat[2].ch, lat[LANE_MIN_UNITS].ch, CH_DOT,
		lat[LANE_HUND_TENS].ch, lat[LANE_HUND_UNITS].ch,
		lat[LANE_MIN_UNITS].is_digit ? CH_S : CH_N};

	always_comb begin
		deg_raw = {1'b0, lon[LANE_DEG].val} + (lat[LANE_HUND_TENS].at_p ? DEG_HUNDRED : 8'd0);
		if (deg_raw inside {[FOLD_LO:FOLD_HI]}) begin
			deg_fold = deg_raw - FOLD_SUB;
		end else if (deg_raw inside {[WRAP_LO:WRAP_HI]}) begin
			deg_fold = deg_raw - WRAP_LO;
		end else begin
			deg_fold = deg_raw;
		end
		deg_hund = (deg_fold >= DEG_HUNDRED);
		deg_rem  = deg_hund ? (deg_fold - DEG_HUNDRED) : deg_fold;
		min_val  = (lon[LANE_MIN].val >= MIN_WRAP) ? (lon[LANE_MIN].val - MIN_WRAP)
			: lon[LANE_MIN].val;
		if (field_error) begin
			lon_text = '0;
		end else begin
			lon_text = {digit_char({3'b000, deg_hund}), two_digits(deg_rem[6:0]),
				two_digits(min_val), CH_DOT, two_digits(lon[LANE_HUND].val)};
		end
	end

endmodule

[hw/rtl/mepd_checker.sv]
// ----------------------------------------------------------------------------
// mepd_checker
// Port-level checks on the decoder's result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "mic_e_position_decoder_core_assert.svh"

module mepd_checker
	import mepd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] latitude_text,
	input logic [63:0] longitude_text,
	input logic        field_error
);

	`MEPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(latitude_text) && $stable(longitude_text), "stalled result word changed")
	`MEPD_ASSERT_NOW(a_err_zero, out_valid && field_error, longitude_text == 64'd0, "longitude text not cleared on field error")
	`MEPD_ASSERT_NOW(a_lat_dot, out_valid, latitude_text[31:24] == CH_DOT, "latitude separator missing")
	`MEPD_ASSERT_NOW(a_lat_hemi, out_valid, latitude_text[7:0] == CH_N || latitude_text[7:0] == CH_S, "bad latitude hemisphere")
	`MEPD_ASSERT_NOW(a_lon_dot, out_valid && !field_error, longitude_text[23:16] == CH_DOT, "longitude separator missing")

endmodule

bind mic_e_position_decoder_core mepd_checker u_mepd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.latitude_text  (latitude_text),
	.longitude_text (longitude_text),
	.field_error    (field_error)
);
